/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the tag manager, used by lru_block_cache_tags.
// Standalone header; the using module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lbct_pkg.sv */
// Package of the LRU block cache tag manager: sizes, codes and types.
// No dependencies; used by lbct_cell and lru_block_cache_tags.
package lbct_pkg;

  localparam int WAYS        = 16;
  localparam int WAY_W       = $clog2(WAYS);
  localparam int BLOCK_BYTES = 64 * 1024;
  localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);
  localparam int TAG_W       = 48;
  localparam int LEN_W       = 17;
  localparam int STAMP_W     = 64;
  localparam int SIZE_W      = 64;
  localparam int OUT_WAY_W   = 4;
  localparam int PROD_W      = SIZE_W + BLK_SHIFT;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_MISS    = 3'd1,
    ST_BEYOND  = 3'd2,
    ST_FILLED  = 3'd3,
    ST_BAD     = 3'd4,
    ST_CHANGED = 3'd5,
    ST_NOPEND  = 3'd6
  } status_t;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_FILL   = 1'b1
  } op_t;

  // victim candidate travelling along the row of cells
  typedef struct packed {
    logic               first;
    logic [WAY_W-1:0]   pos;
    logic [WAY_W-1:0]   way;
    logic               valid;
    logic [STAMP_W-1:0] stamp;
  } cand_t;

  typedef struct packed {
    logic  stb;
    cand_t cand;
  } carry_t;

  typedef struct packed {
    logic               install;
    logic [TAG_W-1:0]   tag;
    logic [LEN_W-1:0]   length;
    logic [STAMP_W-1:0] stamp;
  } wr_t;

  typedef struct packed {
    status_t            status;
    logic [WAY_W-1:0]   way;
    logic [SIZE_W-1:0]  offset;
    logic [LEN_W-1:0]   bytes;
    logic [SIZE_W-1:0]  ksize;
    logic               known;
  } res_t;

  function automatic logic [OUT_WAY_W-1:0] to_way4(input logic [WAY_W-1:0] w);
    logic [WAY_W+OUT_WAY_W-1:0] ext;
    ext = (WAY_W + OUT_WAY_W)'(w);
    return ext[OUT_WAY_W-1:0];
  endfunction

endpackage

/* rtl/lbct_cell.sv */
// One way of the tag store: valid, tag, length and age stamp, tag compare,
// and one step of the victim sweep. Depends on lbct_pkg.
module lbct_cell import lbct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  wr_t              wr,
  input  logic [TAG_W-1:0] look_tag,
  output logic             hit,
  output logic [LEN_W-1:0] length,
  input  carry_t           carry_in,
  output carry_t           carry_out
);

  logic               valid_r;
  logic [TAG_W-1:0]   tag_r;
  logic [LEN_W-1:0]   len_r;
  logic [STAMP_W-1:0] stamp_r;
  logic               stb_r;
  cand_t              cand_r;
  logic               take;

  assign hit    = valid_r && (tag_r == look_tag);
  assign length = len_r;

  assign take = carry_in.cand.first || !valid_r ||
                (carry_in.cand.valid && (stamp_r < carry_in.cand.stamp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      stb_r   <= 1'b0;
    end else begin
      stb_r <= carry_in.stb;
      if (we && wr.install) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      stamp_r <= wr.stamp;
      if (wr.install) begin
        tag_r <= wr.tag;
        len_r <= wr.length;
      end
    end
    if (carry_in.stb) begin
      cand_r.first <= 1'b0;
      cand_r.pos   <= carry_in.cand.pos + WAY_W'(1);
      cand_r.way   <= take ? carry_in.cand.pos : carry_in.cand.way;
      cand_r.valid <= take ? valid_r : carry_in.cand.valid;
      cand_r.stamp <= take ? stamp_r : carry_in.cand.stamp;
    end
  end

  assign carry_out = '{stb: stb_r, cand: cand_r};

endmodule

/* rtl/lru_block_cache_tags.sv */
// Timing: an accepted beat is registered and evaluated in S_EVAL; a miss starts
// the victim sweep through the row of way cells, one cell per cycle. Each result
// is registered into the output slot (via S_HOLD while it is full); a new beat is
// accepted only in S_IDLE, once the last result has entered the slot.
// Reset: synchronous, clears valid bits, stamp counter, learned size and the
// pending fetch; no clearing pass. Depends on lbct_pkg and lbct_cell.
`include "assert_macros.svh"

module lru_block_cache_tags import lbct_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [47:0] block_index, [64:48] fill_bytes, [65] fill_end_seen,
  // [129:66] fill_size, [130] fill_size_valid, [135:131] zero
  input  logic [135:0] in_tdata,
  // [0] operation
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [3:0] way, [67:4] fetch_offset, [84:68] block_bytes,
  // [148:85] known_size, [149] size_is_known, [151:150] zero
  output logic [151:0] out_tdata,
  // [2:0] status
  output logic [2:0]   out_tuser
);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_SWEEP, S_HOLD} state_t;

  state_t             state_r;
  logic               out_valid_r;
  res_t               out_r;
  res_t               res_r;

  op_t                op_r;
  logic [TAG_W-1:0]   idx_r;
  logic [LEN_W-1:0]   bytes_r;
  logic               end_r;
  logic [SIZE_W-1:0]  fsize_r;
  logic               fsv_r;

  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [SIZE_W-1:0]  lsize_r, lsize_nxt;
  logic               learned_r, learned_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [WAY_W-1:0]   pend_way_r, pend_way_nxt;
  logic [TAG_W-1:0]   pend_tag_r, pend_tag_nxt;

  logic [WAYS-1:0]    hit_vec;
  logic [LEN_W-1:0]   len_vec [WAYS];
  carry_t             carries [WAYS+1];
  logic [WAYS-1:0]    we;
  wr_t                wr;

  logic               in_acc, slot_free, done, start, out_load;
  res_t               res;
  logic [PROD_W-1:0]  prod_look, prod_fill;
  logic [SIZE_W-1:0]  off_look, off_fill;
  logic               beyond, bad, changed;
  logic [WAY_W-1:0]   hit_way;
  logic [LEN_W-1:0]   hit_len;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign out_load  = slot_free && (done || (state_r == S_HOLD));

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {2'b00, out_r.known, out_r.ksize, out_r.bytes, out_r.offset,
                       to_way4(out_r.way)};

  assign carries[0] = '{stb: start,
                        cand: '{first: 1'b1, pos: '0, way: '0, valid: 1'b0, stamp: '0}};

  for (genvar g = 0; g < WAYS; g++) begin : g_cell
    lbct_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .we        (we[g]),
      .wr        (wr),
      .look_tag  (idx_r),
      .hit       (hit_vec[g]),
      .length    (len_vec[g]),
      .carry_in  (carries[g]),
      .carry_out (carries[g+1])
    );
  end

  always_comb begin
    hit_way = '0;
    hit_len = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (hit_vec[i]) begin
        hit_way = hit_way | WAY_W'(i);
        hit_len = hit_len | len_vec[i];
      end
    end
  end

  assign prod_look = PROD_W'(idx_r) << BLK_SHIFT;
  assign off_look  = prod_look[SIZE_W-1:0];
  assign prod_fill = PROD_W'(pend_tag_r) << BLK_SHIFT;
  assign off_fill  = prod_fill[SIZE_W-1:0];

  assign beyond  = (|prod_look[PROD_W-1:SIZE_W]) || (learned_r && (off_look >= lsize_r));
  assign bad     = (32'(bytes_r) > BLOCK_BYTES) || ((bytes_r == '0) && !end_r);
  assign changed = fsv_r && learned_r && (lsize_r != fsize_r);

  always_comb begin
    stamp_nxt      = stamp_r;
    lsize_nxt      = lsize_r;
    learned_nxt    = learned_r;
    pend_valid_nxt = pend_valid_r;
    pend_way_nxt   = pend_way_r;
    pend_tag_nxt   = pend_tag_r;
    we             = '0;
    wr             = '{install: 1'b0, tag: pend_tag_r, length: bytes_r,
                       stamp: stamp_r + STAMP_W'(1)};
    done           = 1'b0;
    start          = 1'b0;
    res            = '{status: ST_HIT, way: '0, offset: '0, bytes: '0, ksize: '0,
                       known: 1'b0};
    if (state_r == S_EVAL) begin
      if (op_r == OP_LOOKUP) begin
        if (beyond) begin
          res.status = ST_BEYOND;
          done       = 1'b1;
        end else if (|hit_vec) begin
          stamp_nxt  = stamp_r + STAMP_W'(1);
          we         = hit_vec;
          res.status = ST_HIT;
          res.way    = hit_way;
          res.bytes  = hit_len;
          done       = 1'b1;
        end else begin
          start = 1'b1;
        end
      end else begin
        done = 1'b1;
        if (!pend_valid_r) begin
          res.status = ST_NOPEND;
        end else begin
          pend_valid_nxt = 1'b0;
          res.way        = pend_way_r;
          if (bad) begin
            res.status = ST_BAD;
          end else if (changed) begin
            res.status = ST_CHANGED;
          end else begin
            if (fsv_r) begin
              lsize_nxt   = fsize_r;
              learned_nxt = 1'b1;
            end else if (end_r) begin
              lsize_nxt   = off_fill + SIZE_W'(bytes_r);
              learned_nxt = 1'b1;
            end
            we         = WAYS'(1) << pend_way_r;
            wr.install = 1'b1;
            stamp_nxt  = stamp_r + STAMP_W'(1);
            res.status = ST_FILLED;
            res.bytes  = bytes_r;
          end
        end
      end
    end else if ((state_r == S_SWEEP) && carries[WAYS].stb) begin
      pend_valid_nxt = 1'b1;
      pend_way_nxt   = carries[WAYS].cand.way;
      pend_tag_nxt   = idx_r;
      res.status     = ST_MISS;
      res.way        = carries[WAYS].cand.way;
      res.offset     = off_look;
      done           = 1'b1;
    end
    res.ksize = lsize_nxt;
    res.known = learned_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_tready);
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL, S_SWEEP: begin
          if (done) begin
            if (slot_free) begin
              out_r   <= res;
              state_r <= S_IDLE;
            end else begin
              res_r   <= res;
              state_r <= S_HOLD;
            end
          end else if (start) begin
            state_r <= S_SWEEP;
          end
        end
        S_HOLD: begin
          if (slot_free) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r      <= '0;
      lsize_r      <= '0;
      learned_r    <= 1'b0;
      pend_valid_r <= 1'b0;
      pend_way_r   <= '0;
      pend_tag_r   <= '0;
    end else begin
      stamp_r      <= stamp_nxt;
      lsize_r      <= lsize_nxt;
      learned_r    <= learned_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_way_r   <= pend_way_nxt;
      pend_tag_r   <= pend_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= op_t'(in_tuser[0]);
      idx_r   <= in_tdata[47:0];
      bytes_r <= in_tdata[64:48];
      end_r   <= in_tdata[65];
      fsize_r <= in_tdata[129:66];
      fsv_r   <= in_tdata[130];
    end
  end

  `ASSERT_NEXT(a_accept_eval, in_tvalid && in_tready, state_r == S_EVAL, "beat not evaluated")
  `ASSERT_RST(a_sweep_end, carries[WAYS].stb |-> state_r == S_SWEEP, "stray sweep end")
  `ASSERT_RST(a_hit_onehot, $onehot0(hit_vec), "tag held by two ways")
  `ASSERT_NEXT(a_miss_pend, state_r == S_SWEEP && carries[WAYS].stb, pend_valid_r, "miss not pending")

endmodule

/* verif/tb.sv */
// Self-checking bench for lru_block_cache_tags: directed tests and random lookup/fill
// traffic, checked beat by beat against an in-bench tag/LRU predictor.
// Depends on lbct_pkg and the RTL of lru_block_cache_tags.
module tb;
  import lbct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          POOL        = 24;
  localparam int          HOLD_CYCLES = 300;
  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [47:0] MAX_INDEX   = {48{1'b1}};

  typedef struct {
    status_t     status;
    logic [3:0]  way;
    logic [63:0] offset;
    logic [16:0] bytes;
    logic [63:0] ksize;
    logic        known;
  } tag_answer_t;

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata   = '0;   // [47:0] index, [64:48] bytes, [65] eof, [129:66] size, [130] size ok
  logic [0:0]   in_tuser   = '0;   // [0] operation
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;         // [3:0] way, [67:4] offset, [84:68] bytes, [148:85] size, [149] known
  logic [2:0]   out_tuser;         // [2:0] status

  lru_block_cache_tags dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // predictor state
  logic        way_valid [WAYS] = '{default: 1'b0};
  logic [47:0] way_tag   [WAYS] = '{default: '0};
  logic [16:0] way_len   [WAYS] = '{default: '0};
  logic [63:0] way_stamp [WAYS] = '{default: '0};
  logic [63:0] stamp_ctr  = '0;
  logic [63:0] size_val   = '0;
  logic        size_known = 1'b0;
  logic        pend_valid = 1'b0;
  int          pend_way   = 0;
  logic [47:0] pend_tag   = '0;

  tag_answer_t expected_answers[$];
  tag_answer_t seen_exp;
  logic [47:0] tag_pool [POOL];
  int          status_seen [8] = '{default: 0};
  int          mismatches    = 0;
  int          beats_sent    = 0;
  int          cycle_count   = 0;
  int          hold_requests = 0;
  int          holds_done    = 0;
  int          rx_hold       = 0;
  int          rx_wait       = 0;
  int          rx_gap;
  bit          tx_steady     = 1'b0;
  bit          rx_steady     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_answers.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic tag_answer_t cache_tag_predict(input op_t op, input logic [47:0] idx,
                                                    input logic [16:0] got, input logic eof,
                                                    input logic [63:0] sz, input logic sz_ok);
    tag_answer_t a;
    logic [63:0] offset;
    int          hit;
    int          victim;
    a.status = ST_HIT;
    a.way    = '0;
    a.offset = '0;
    a.bytes  = '0;
    if (op == OP_LOOKUP) begin
      offset = 64'(idx) << BLK_SHIFT;
      if (size_known && offset >= size_val) begin
        a.status = ST_BEYOND;
      end else begin
        hit    = -1;
        victim = 0;
        for (int i = 0; i < WAYS; i++) begin
          if (hit < 0) begin
            if (way_valid[i] && way_tag[i] == idx) hit = i;
            else if (i == 0 || !way_valid[i] ||
                     (way_valid[victim] && way_stamp[i] < way_stamp[victim])) victim = i;
          end
        end
        if (hit >= 0) begin
          stamp_ctr      = stamp_ctr + 1;
          way_stamp[hit] = stamp_ctr;
          a.way          = 4'(hit);
          a.bytes        = way_len[hit];
        end else begin
          pend_valid = 1'b1;
          pend_way   = victim;
          pend_tag   = idx;
          a.status   = ST_MISS;
          a.way      = 4'(victim);
          a.offset   = offset;
        end
      end
    end else if (!pend_valid) begin
      a.status = ST_NOPEND;
    end else begin
      pend_valid = 1'b0;
      a.way      = 4'(pend_way);
      if (got > 17'(BLOCK_BYTES) || (got == '0 && !eof)) begin
        a.status = ST_BAD;
      end else if (sz_ok && size_known && size_val != sz) begin
        a.status = ST_CHANGED;
      end else begin
        if (sz_ok) begin
          size_val   = sz;
          size_known = 1'b1;
        end else if (eof) begin
          size_val   = (64'(pend_tag) << BLK_SHIFT) + 64'(got);
          size_known = 1'b1;
        end
        way_valid[pend_way] = 1'b1;
        way_tag[pend_way]   = pend_tag;
        way_len[pend_way]   = got;
        stamp_ctr           = stamp_ctr + 1;
        way_stamp[pend_way] = stamp_ctr;
        a.status            = ST_FILLED;
        a.bytes             = got;
      end
    end
    a.ksize = size_val;
    a.known = size_known;
    return a;
  endfunction

  // receiver: random stall (possibly none) after each beat, plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold    <= rx_hold - 1;
    end else if (holds_done != hold_requests) begin
      out_tready <= 1'b0;
      rx_hold    <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else if (rx_wait > 0) begin
      out_tready <= 1'b0;
      rx_wait    <= rx_wait - 1;
    end else if (out_tready && out_tvalid) begin
      rx_gap = rx_steady ? 0 : $urandom_range(0, 3);
      out_tready <= (rx_gap == 0);
      rx_wait    <= (rx_gap == 0) ? 0 : rx_gap - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result beat: status %0d way %0d", out_tuser, out_tdata[3:0]);
        mismatches++;
      end else begin
        seen_exp = expected_answers.pop_front();
        status_seen[int'(seen_exp.status)]++;
        if (out_tuser !== seen_exp.status) begin
          $error("status: expected %0d, got %0d", seen_exp.status, out_tuser);
          mismatches++;
        end
        if (out_tdata[3:0] !== seen_exp.way) begin
          $error("way: expected %0d, got %0d", seen_exp.way, out_tdata[3:0]);
          mismatches++;
        end
        if (out_tdata[67:4] !== seen_exp.offset) begin
          $error("fetch_offset: expected %h, got %h", seen_exp.offset, out_tdata[67:4]);
          mismatches++;
        end
        if (out_tdata[84:68] !== seen_exp.bytes) begin
          $error("block_bytes: expected %0d, got %0d", seen_exp.bytes, out_tdata[84:68]);
          mismatches++;
        end
        if (out_tdata[148:85] !== seen_exp.ksize) begin
          $error("known_size: expected %h, got %h", seen_exp.ksize, out_tdata[148:85]);
          mismatches++;
        end
        if (out_tdata[149] !== seen_exp.known) begin
          $error("size_is_known: expected %0d, got %0d", seen_exp.known, out_tdata[149]);
          mismatches++;
        end
      end
    end
  end

  task automatic send_beat(input op_t op, input logic [47:0] idx, input logic [16:0] got,
                           input logic eof, input logic [63:0] sz, input logic sz_ok);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'd0, sz_ok, sz, eof, got, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    expected_answers.push_back(cache_tag_predict(op, idx, got, eof, sz, sz_ok));
  endtask

  task automatic lookup(input logic [47:0] idx);
    send_beat(OP_LOOKUP, idx, 17'($urandom), 1'($urandom), {$urandom, $urandom}, 1'($urandom));
  endtask

  task automatic fill(input logic [16:0] got, input logic eof, input logic [63:0] sz,
                      input logic sz_ok);
    send_beat(OP_FILL, {16'($urandom), 32'($urandom)}, got, eof, sz, sz_ok);
  endtask

  // mostly lookup/fill pairs; noise: bad reads, size conflicts, orphan fills
  task automatic random_item();
    int          r;
    logic [16:0] got;
    r = $urandom_range(0, 99);
    if (pend_valid && r < 75) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        got = (r < 7) ? 17'(BLOCK_BYTES) : 17'($urandom_range(1, BLOCK_BYTES));
        if ($urandom_range(0, 1)) fill(got, 1'($urandom_range(0, 1)), size_val, 1'b1);
        else fill(got, 1'b0, {$urandom, $urandom}, 1'b0);
      end else if (r < 78) begin
        fill(17'($urandom_range(0, BLOCK_BYTES)), 1'b1, size_val, 1'b1);
      end else if (r < 82) begin
        fill(17'd0, 1'b0, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
      end else if (r < 86) begin
        fill(17'($urandom_range(BLOCK_BYTES + 1, 131071)), 1'($urandom_range(0, 1)),
             {$urandom, $urandom}, 1'($urandom_range(0, 1)));
      end else if (r < 94) begin
        fill(17'($urandom_range(1, BLOCK_BYTES)), 1'($urandom_range(0, 1)),
             {$urandom, $urandom}, 1'b1);
      end else if (pend_tag == MAX_INDEX) begin
        // end of data on the top block shrinks the size but keeps that block reachable
        fill(17'($urandom_range(1, BLOCK_BYTES - 1)), 1'b1, {$urandom, $urandom}, 1'b0);
      end else begin
        fill(17'($urandom_range(1, BLOCK_BYTES)), 1'b0, {$urandom, $urandom}, 1'b0);
      end
    end else if (!pend_valid && r < 8) begin
      fill(17'($urandom_range(0, 131071)), 1'($urandom), {$urandom, $urandom}, 1'($urandom));
    end else if ($urandom_range(0, 99) < 85) begin
      lookup(tag_pool[$urandom_range(0, POOL - 1)]);
    end else begin
      lookup({16'($urandom), 32'($urandom)});
    end
  endtask

  task automatic test_fill_without_fetch();
    fill(17'd100, 1'b1, 64'd1000, 1'b1);
  endtask

  task automatic test_miss_then_hit();
    lookup(48'd0);
    fill(17'(BLOCK_BYTES), 1'b0, '0, 1'b0);
    lookup(48'd0);
  endtask

  task automatic test_bad_reads();
    lookup(MAX_INDEX);
    fill(17'd0, 1'b0, '0, 1'b0);
    lookup(MAX_INDEX);
    fill(17'h1FFFF, 1'b1, {$urandom, $urandom}, 1'b1);
  endtask

  task automatic test_pending_replacement();
    lookup(48'd1);
    lookup(48'd2);
    lookup(48'd0);
    fill(17'd777, 1'b0, '0, 1'b0);
    lookup(48'd2);
  endtask

  task automatic test_size_learning();
    lookup(48'd3);
    fill(17'd0, 1'b1, {64{1'b1}}, 1'b1);
    lookup(48'd4);
    fill(17'd100, 1'b1, 64'd5, 1'b1);
    lookup(48'd4);
    fill(17'd4096, 1'b0, {64{1'b1}}, 1'b1);
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < 950; n++) begin
      if (n % 100 == 0) begin
        tx_steady = ($urandom_range(0, 4) == 0);
        rx_steady <= ($urandom_range(0, 4) == 0);
      end
      random_item();
    end
    tx_steady = 1'b0;
    rx_steady <= 1'b0;
  endtask

  task automatic test_output_backpressure();
    tx_steady = 1'b1;
    hold_requests <= hold_requests + 1;
    repeat (40) random_item();
    tx_steady = 1'b0;
  endtask

  // evict the top block if cached, then let its fill wrap the size to zero
  task automatic test_end_of_resource();
    bit resident;
    resident = 1'b1;
    while (resident) begin
      resident = 1'b0;
      for (int w = 0; w < WAYS; w++)
        if (way_valid[w] && way_tag[w] == MAX_INDEX) resident = 1'b1;
      if (resident) begin
        lookup({17'd0, 31'($urandom)});
        if (pend_valid) fill(17'd512, 1'b0, '0, 1'b0);
      end
    end
    lookup(MAX_INDEX);
    fill(17'(BLOCK_BYTES), 1'b1, {$urandom, $urandom}, 1'b0);
    lookup(48'd0);
    lookup(MAX_INDEX);
    lookup({16'($urandom), 32'($urandom)});
    fill(17'd64, 1'b1, 64'd0, 1'b1);
  endtask

  initial begin
    for (int i = 0; i < POOL; i++)
      tag_pool[i] = (i < 10) ? 48'(i) : {16'($urandom), 32'($urandom)};
    tag_pool[POOL - 1] = MAX_INDEX;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_without_fetch();
    test_miss_then_hit();
    test_bad_reads();
    test_pending_replacement();
    test_size_learning();
    test_random_traffic();
    test_output_backpressure();
    test_end_of_resource();
    in_tvalid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (WAYS + 8) @(posedge clk);
    $display("%0d beats: %0d hit, %0d miss, %0d beyond end, %0d filled", beats_sent,
             status_seen[ST_HIT], status_seen[ST_MISS], status_seen[ST_BEYOND],
             status_seen[ST_FILLED]);
    $display("%0d bad read, %0d size changed, %0d fill with no fetch; %0d mismatches",
             status_seen[ST_BAD], status_seen[ST_CHANGED], status_seen[ST_NOPEND], mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
